[rtl/adb_mouse_report_chunker_defines.svh]
// Assertion macros for the ADB mouse report chunker.
// Included by the files that assert; no other dependencies.
`ifndef ADB_MOUSE_REPORT_CHUNKER_DEFINES_SVH
`define ADB_MOUSE_REPORT_CHUNKER_DEFINES_SVH

// General form: clock and active-low reset given explicitly
`define ADBM_ASSERT(label, clk_sig, rst_n_sig, prop, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) prop) else $error(msg);

// Short form for checkers that see clk and arst_n
`define ADBM_CHECK(label, prop, msg) \
	`ADBM_ASSERT(label, clk, arst_n, prop, msg)

`endif

[rtl/adbm_pkg.sv]
// Shared types and constants for the ADB mouse report chunker.
// No dependencies.
package adbm_pkg;

	localparam int unsigned DW = 12;   // width of a saturated delta
	localparam int unsigned RW = 17;   // width of a raw position difference
	localparam int unsigned CW = 7;    // width of one chunk

	localparam logic signed [RW-1:0] DELTA_LIMIT = 17'sd2016;
	localparam logic signed [DW-1:0] CHUNK_MIN   = -12'sd64;
	localparam logic signed [DW-1:0] CHUNK_MAX   = 12'sd63;
	localparam logic [7:0]           BTN_RELEASED  = 8'h80;
	localparam logic [7:0]           MARK_BIT      = 8'h80;
	localparam logic [1:0]           LENGTH_VAL    = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CLAMP,
		ST_EMIT
	} state_t;

	// Result of one pass through the chunk unit
	typedef struct packed {
		logic [CW-1:0]        cx;
		logic [CW-1:0]        cy;
		logic signed [DW-1:0] rem_x;
		logic signed [DW-1:0] rem_y;
		logic                 done;
	} chunk_res_t;

endpackage

[rtl/adbm_if.sv]
// Handshake interfaces for mouse updates and reports.
// Depends on nothing; used by the top level of the report chunker.
interface adbm_upd_if;
	logic               valid;
	logic               ready;
	logic               func;
	logic signed [15:0] pos_x;
	logic signed [15:0] pos_y;
	logic signed [11:0] delta_x;
	logic signed [11:0] delta_y;
	logic               button_down;

	modport source (output valid, func, pos_x, pos_y, delta_x, delta_y, button_down,
		input ready);
	modport sink (input valid, func, pos_x, pos_y, delta_x, delta_y, button_down,
		output ready);
endinterface

interface adbm_rpt_if;
	logic       valid;
	logic       ready;
	logic [1:0] length_byte;
	logic [7:0] first_byte;
	logic [7:0] second_byte;
	logic       last_of_run;

	modport source (output valid, length_byte, first_byte, second_byte, last_of_run,
		input ready);
	modport sink (input valid, length_byte, first_byte, second_byte, last_of_run,
		output ready);
endinterface

[rtl/adbm_chunk_unit.sv]
// Shared chunk unit: clamps both remainders to one chunk and subtracts it.
// Depends on adbm_pkg.
module adbm_chunk_unit (
	input  logic signed [adbm_pkg::DW-1:0] rem_x,
	input  logic signed [adbm_pkg::DW-1:0] rem_y,
	output adbm_pkg::chunk_res_t           res
);

	logic signed [adbm_pkg::DW-1:0] cx_full;
	logic signed [adbm_pkg::DW-1:0] cy_full;

	// Clamp each remainder to the chunk range
	always_comb begin
		if (rem_x < adbm_pkg::CHUNK_MIN) begin
			cx_full = adbm_pkg::CHUNK_MIN;
		end else if (rem_x > adbm_pkg::CHUNK_MAX) begin
			cx_full = adbm_pkg::CHUNK_MAX;
		end else begin
			cx_full = rem_x;
		end
		if (rem_y < adbm_pkg::CHUNK_MIN) begin
			cy_full = adbm_pkg::CHUNK_MIN;
		end else if (rem_y > adbm_pkg::CHUNK_MAX) begin
			cy_full = adbm_pkg::CHUNK_MAX;
		end else begin
			cy_full = rem_y;
		end
	end

	// Subtract the chunk and flag the end of the run
	always_comb begin
		res.cx    = cx_full[adbm_pkg::CW-1:0];
		res.cy    = cy_full[adbm_pkg::CW-1:0];
		res.rem_x = rem_x - cx_full;
		res.rem_y = rem_y - cy_full;
		res.done  = (res.rem_x == '0) && (res.rem_y == '0);
	end

endmodule

[rtl/adb_mouse_report_chunker.sv]
// Top level of the ADB mouse report chunker: sequencer, delta registers, report register.
// Depends on adbm_pkg, adbm_if.sv and adbm_chunk_unit.
//
// Usage:
//   upd carries one mouse update per transaction (func, position, deltas, button).
//   rpt carries three-byte ADB register-0 reports, one per transaction, with
//   last_of_run marking the final report of an update.
//   cfg_wr_en/cfg_wr_data write handler_installed; write it only while idle.
// Sequencing:
//   After an update is taken, its raw deltas are registered and then saturated into
//   the remainder registers; reports then go through the report register, one per
//   cycle from the shared chunk unit while rpt is not stalled. An update gives N
//   reports (1 to 32). upd.ready stays low while reports are being produced.
//   With no handler installed an update gives no report and the block stays idle.
// Stalls:
//   A report is held in the output register until rpt.ready; the run pauses
//   meanwhile. The next update may be taken while the last report still waits.
// Reset:
//   arst_n clears the stored position, the first-update flag, the handler flag
//   and the report valid; the block comes up idle and ready.
module adb_mouse_report_chunker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic       cfg_wr_data,
	adbm_upd_if.sink   upd,
	adbm_rpt_if.source rpt
);

	adbm_pkg::state_t state_q;
	adbm_pkg::state_t state_nxt;

	logic                                 handler_q;
	logic                                 seen_q;
	logic signed [15:0]                   prev_x_q;
	logic signed [15:0]                   prev_y_q;
	logic signed [adbm_pkg::RW-1:0]       raw_x_q;
	logic signed [adbm_pkg::RW-1:0]       raw_y_q;
	logic signed [adbm_pkg::DW-1:0]       rem_x_q;
	logic signed [adbm_pkg::DW-1:0]       rem_y_q;
	logic                                 button_q;

	logic                                 rpt_valid_q;
	logic [7:0]                           first_q;
	logic [7:0]                           second_q;
	logic                                 last_q;

	logic                                 upd_fire;
	logic                                 rpt_free;
	logic                                 upd_ready;
	logic                                 clamp_en;
	logic                                 load_rpt;
	logic signed [adbm_pkg::RW-1:0]       diff_x;
	logic signed [adbm_pkg::RW-1:0]       diff_y;
	logic signed [adbm_pkg::DW-1:0]       sat_x;
	logic signed [adbm_pkg::DW-1:0]       sat_y;
	adbm_pkg::chunk_res_t                 res;

	assign upd_fire = upd.valid && upd_ready;
	assign rpt_free = !rpt_valid_q || rpt.ready;

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			adbm_pkg::ST_IDLE: begin
				if (upd_fire && handler_q) begin
					state_nxt = adbm_pkg::ST_CLAMP;
				end
			end
			adbm_pkg::ST_CLAMP: begin
				state_nxt = adbm_pkg::ST_EMIT;
			end
			adbm_pkg::ST_EMIT: begin
				if (rpt_free && res.done) begin
					state_nxt = adbm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = adbm_pkg::ST_IDLE;
			end
		endcase
	end

	// Sequencer outputs
	always_comb begin
		upd_ready = 1'b0;
		clamp_en  = 1'b0;
		load_rpt  = 1'b0;
		case (state_q)
			adbm_pkg::ST_IDLE:  upd_ready = 1'b1;
			adbm_pkg::ST_CLAMP: clamp_en  = 1'b1;
			adbm_pkg::ST_EMIT:  load_rpt  = rpt_free;
			default: begin
				upd_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= adbm_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Hold the handler flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			handler_q <= 1'b0;
		end else if (cfg_wr_en) begin
			handler_q <= cfg_wr_data;
		end
	end

	// Raw deltas: supplied when func is set, else position change (zero before any update was taken)
	always_comb begin
		if (upd.func) begin
			diff_x = adbm_pkg::RW'(upd.delta_x);
			diff_y = adbm_pkg::RW'(upd.delta_y);
		end else if (!seen_q) begin
			diff_x = '0;
			diff_y = '0;
		end else begin
			diff_x = adbm_pkg::RW'(upd.pos_x) - adbm_pkg::RW'(prev_x_q);
			diff_y = adbm_pkg::RW'(upd.pos_y) - adbm_pkg::RW'(prev_y_q);
		end
	end

	// Track the stored position on every update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q   <= 1'b0;
			prev_x_q <= '0;
			prev_y_q <= '0;
		end else if (upd_fire) begin
			seen_q   <= 1'b1;
			prev_x_q <= upd.pos_x;
			prev_y_q <= upd.pos_y;
		end
	end

	// Capture the raw deltas and button
	always_ff @(posedge clk) begin
		if (upd_fire) begin
			raw_x_q  <= diff_x;
			raw_y_q  <= diff_y;
			button_q <= upd.button_down;
		end
	end

	// Saturate the raw deltas
	always_comb begin
		if (raw_x_q > adbm_pkg::DELTA_LIMIT) begin
			sat_x = adbm_pkg::DW'(adbm_pkg::DELTA_LIMIT);
		end else if (raw_x_q < -adbm_pkg::DELTA_LIMIT) begin
			sat_x = adbm_pkg::DW'(-adbm_pkg::DELTA_LIMIT);
		end else begin
			sat_x = raw_x_q[adbm_pkg::DW-1:0];
		end
		if (raw_y_q > adbm_pkg::DELTA_LIMIT) begin
			sat_y = adbm_pkg::DW'(adbm_pkg::DELTA_LIMIT);
		end else if (raw_y_q < -adbm_pkg::DELTA_LIMIT) begin
			sat_y = adbm_pkg::DW'(-adbm_pkg::DELTA_LIMIT);
		end else begin
			sat_y = raw_y_q[adbm_pkg::DW-1:0];
		end
	end

	adbm_chunk_unit u_chunk (
		.rem_x (rem_x_q),
		.rem_y (rem_y_q),
		.res   (res)
	);

	// Load saturated deltas, then advance the remainders one chunk per report
	always_ff @(posedge clk) begin
		if (clamp_en) begin
			rem_x_q <= sat_x;
			rem_y_q <= sat_y;
		end else if (load_rpt) begin
			rem_x_q <= res.rem_x;
			rem_y_q <= res.rem_y;
		end
	end

	// Report register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rpt_valid_q <= 1'b0;
		end else if (load_rpt) begin
			rpt_valid_q <= 1'b1;
		end else if (rpt.ready) begin
			rpt_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_rpt) begin
			first_q  <= {1'b0, res.cy} | (button_q ? 8'h00 : adbm_pkg::BTN_RELEASED);
			second_q <= {1'b0, res.cx} | adbm_pkg::MARK_BIT;
			last_q   <= res.done;
		end
	end

	assign upd.ready       = upd_ready;
	assign rpt.valid       = rpt_valid_q;
	assign rpt.length_byte = adbm_pkg::LENGTH_VAL;
	assign rpt.first_byte  = first_q;
	assign rpt.second_byte = second_q;
	assign rpt.last_of_run = last_q;

endmodule

[rtl/adbm_checker.sv]
// Port-level checker for the ADB mouse report chunker, bound to the top level.
// Depends on adb_mouse_report_chunker_defines.svh and adb_mouse_report_chunker.
`include "adb_mouse_report_chunker_defines.svh"

module adbm_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       upd_ready,
	input logic       rpt_valid,
	input logic       rpt_ready,
	input logic [1:0] length_byte,
	input logic [7:0] first_byte,
	input logic [7:0] second_byte,
	input logic       last_of_run
);

	// Every report has payload length two
	`ADBM_CHECK(a_length, rpt_valid |-> (length_byte == 2'd2), "report length is not 2")

	// The dx byte always carries its mark bit
	`ADBM_CHECK(a_mark, rpt_valid |-> second_byte[7], "second byte mark bit clear")

	// No new update is taken while a run is still in progress
	`ADBM_CHECK(a_busy, (rpt_valid && !last_of_run) |-> !upd_ready, "update accepted mid-run")

	// A stalled report holds its contents
	`ADBM_CHECK(a_hold, (rpt_valid && !rpt_ready) |=> (rpt_valid && $stable(first_byte) && $stable(second_byte) && $stable(last_of_run)), "stalled report changed")

endmodule

bind adb_mouse_report_chunker adbm_checker u_adbm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.upd_ready   (upd.ready),
	.rpt_valid   (rpt.valid),
	.rpt_ready   (rpt.ready),
	.length_byte (rpt.length_byte),
	.first_byte  (rpt.first_byte),
	.second_byte (rpt.second_byte),
	.last_of_run (rpt.last_of_run)
);
